// ----- hdl/assert_macros.svh -----
// Assertion macros used by the symmetry transform RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define SCT_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Checked on every rising clock edge, reset included.
`define SCT_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- hdl/sct_pkg.sv -----
// Types, constants and helpers of the symmetry coordinate transform.
package sct_pkg;

   localparam int COORD_W   = 32;
   localparam int COEF_W    = 21;
   localparam int REG_W     = 63;
   localparam int NUM_REGS  = 8;
   localparam int IDX_W     = 3;
   localparam int SLOT_W    = 16;
   localparam int FRAC_DROP = 14;

   // first product, coefficient times coordinate
   localparam int PROD1_W = COEF_W + COORD_W;
   // wide intermediate vector, never saturated
   localparam int ACC_W   = 42;
   // second product is split into a low unsigned and a high signed part
   localparam int SPLIT_W = 21;
   localparam int PL_W    = COEF_W + SPLIT_W + 1;
   localparam int PH_W    = COEF_W + (ACC_W - SPLIT_W);
   localparam int PROD2_W = COEF_W + ACC_W;
   localparam int TERM_W  = PROD2_W - FRAC_DROP;
   localparam int SUM_W   = TERM_W + 2;

   // register indexes
   localparam logic [IDX_W-1:0] REG_FIRST_ROW0   = 3'd0;
   localparam logic [IDX_W-1:0] REG_FIRST_ROW1   = 3'd1;
   localparam logic [IDX_W-1:0] REG_FIRST_ROW2   = 3'd2;
   localparam logic [IDX_W-1:0] REG_FIRST_TRANS  = 3'd3;
   localparam logic [IDX_W-1:0] REG_SECOND_ROW0  = 3'd4;
   localparam logic [IDX_W-1:0] REG_SECOND_ROW1  = 3'd5;
   localparam logic [IDX_W-1:0] REG_SECOND_ROW2  = 3'd6;
   localparam logic [IDX_W-1:0] REG_SECOND_TRANS = 3'd7;

   // identity rows: 1.0 in Q6.14 in the matching column
   localparam logic [REG_W-1:0] ROW0_RESET  = 63'd16384;
   localparam logic [REG_W-1:0] ROW1_RESET  = 63'd34359738368;
   localparam logic [REG_W-1:0] ROW2_RESET  = 63'd72057594037927936;
   localparam logic [REG_W-1:0] TRANS_RESET = 63'd0;

   typedef logic signed [COEF_W-1:0]  coef_type;
   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [ACC_W-1:0]   acc_type;

   localparam acc_type ACC_ONE     = 42'sd65536;
   localparam acc_type ACC_NEG_ONE = -42'sd65536;
   localparam acc_type ACC_TWO     = 42'sd131072;

   localparam coord_type COORD_MAX = 32'sh7FFF_FFFF;
   localparam coord_type COORD_MIN = 32'sh8000_0000;

   typedef struct packed {
      logic [SLOT_W-1:0] slot;
      logic              last;
   } tag_type;

   typedef struct packed {
      logic [2:0][REG_W-1:0] m1;
      logic [REG_W-1:0]      t1;
      logic [2:0][REG_W-1:0] m2;
      logic [REG_W-1:0]      t2;
   } cfg_type;

   // coefficient k of a packed register, column 0 in the low bits
   function automatic coef_type coef_of(input logic [REG_W-1:0] r, input logic [1:0] k);
      coef_of = r[COEF_W*k +: COEF_W];
   endfunction

   // translation k widened from 14 to 16 fraction bits
   function automatic acc_type trans_of(input logic [REG_W-1:0] r, input logic [1:0] k);
      trans_of = acc_type'(coef_of(r, k)) <<< 2;
   endfunction

endpackage

// ----- hdl/sct_csr.sv -----
// Configuration register file of the symmetry transform.
module sct_csr
   import sct_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [IDX_W-1:0] csr_index,
   input  logic [REG_W-1:0] csr_data,
   output cfg_type          cfg
);

   logic [REG_W-1:0] regs_ff [NUM_REGS];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff[REG_FIRST_ROW0]   <= ROW0_RESET;
         regs_ff[REG_FIRST_ROW1]   <= ROW1_RESET;
         regs_ff[REG_FIRST_ROW2]   <= ROW2_RESET;
         regs_ff[REG_FIRST_TRANS]  <= TRANS_RESET;
         regs_ff[REG_SECOND_ROW0]  <= ROW0_RESET;
         regs_ff[REG_SECOND_ROW1]  <= ROW1_RESET;
         regs_ff[REG_SECOND_ROW2]  <= ROW2_RESET;
         regs_ff[REG_SECOND_TRANS] <= TRANS_RESET;
      end else if (csr_valid) begin
         regs_ff[csr_index] <= csr_data;
      end
   end

   always_comb begin
      cfg.m1[0] = regs_ff[REG_FIRST_ROW0];
      cfg.m1[1] = regs_ff[REG_FIRST_ROW1];
      cfg.m1[2] = regs_ff[REG_FIRST_ROW2];
      cfg.t1    = regs_ff[REG_FIRST_TRANS];
      cfg.m2[0] = regs_ff[REG_SECOND_ROW0];
      cfg.m2[1] = regs_ff[REG_SECOND_ROW1];
      cfg.m2[2] = regs_ff[REG_SECOND_ROW2];
      cfg.t2    = regs_ff[REG_SECOND_TRANS];
   end

endmodule

// ----- hdl/sct_first_xform.sv -----
// First three pipeline stages: R1 product, add T1, wrap and subtract T2.
module sct_first_xform
   import sct_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  cfg_type                 cfg,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic [2:0][COORD_W-1:0] in_p,
   input  tag_type                 in_tag,
   output logic                    out_valid,
   input  logic                    out_ready,
   output logic [2:0][ACC_W-1:0]   out_f,
   output tag_type                 out_tag
);

   logic [2:0] vld_ff;
   logic [2:0] rdy;

   logic signed [PROD1_W-1:0] prod_ff [3][3];
   logic signed [PROD1_W-1:0] prod_in [3][3];
   acc_type                   sum_ff [3];
   acc_type                   sum_in [3];
   acc_type                   f_ff [3];
   acc_type                   f_in [3];
   tag_type                   tag_ff [3];

   // a stage takes a new word when empty or when its successor moves on
   always_comb begin
      rdy[2]   = !vld_ff[2] || out_ready;
      rdy[1]   = !vld_ff[1] || rdy[2];
      rdy[0]   = !vld_ff[0] || rdy[1];
      in_ready = rdy[0];
   end

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         for (int k = 0; k < 3; k++) begin
            prod_in[j][k] = coef_of(cfg.m1[j], 2'(k)) * $signed(in_p[k]);
         end
      end
   end

   // floor each product to 16 fraction bits, then sum with T1
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         sum_in[j] = trans_of(cfg.t1, 2'(j))
                   + ACC_W'(prod_ff[j][0] >>> FRAC_DROP)
                   + ACC_W'(prod_ff[j][1] >>> FRAC_DROP)
                   + ACC_W'(prod_ff[j][2] >>> FRAC_DROP);
      end
   end

   always_comb begin
      acc_type w;
      w = '0;
      for (int j = 0; j < 3; j++) begin
         w = sum_ff[j];
         if (w > ACC_ONE) begin
            w = w - ACC_ONE;
         end else if (w < ACC_NEG_ONE) begin
            w = w + ACC_TWO;
         end else if (w < 0) begin
            w = w + ACC_ONE;
         end
         f_in[j] = w - trans_of(cfg.t2, 2'(j));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (rdy[0]) vld_ff[0] <= in_valid;
         if (rdy[1]) vld_ff[1] <= vld_ff[0];
         if (rdy[2]) vld_ff[2] <= vld_ff[1];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         prod_ff   <= prod_in;
         tag_ff[0] <= in_tag;
      end
      if (rdy[1]) begin
         sum_ff    <= sum_in;
         tag_ff[1] <= tag_ff[0];
      end
      if (rdy[2]) begin
         f_ff      <= f_in;
         tag_ff[2] <= tag_ff[1];
      end
   end

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         out_f[j] = f_ff[j];
      end
   end

   assign out_valid = vld_ff[2];
   assign out_tag   = tag_ff[2];

endmodule

// ----- hdl/sct_second_xform.sv -----
// Last three pipeline stages: split R2 product, recombine and floor, sum and saturate.
`include "assert_macros.svh"

module sct_second_xform
   import sct_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  cfg_type                 cfg,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic [2:0][ACC_W-1:0]   in_f,
   input  tag_type                 in_tag,
   output logic                    out_valid,
   input  logic                    out_ready,
   output logic [2:0][COORD_W-1:0] out_r,
   output tag_type                 out_tag
);

   logic [2:0] vld_ff;
   logic [2:0] rdy;

   logic signed [PL_W-1:0]    pl_ff [3][3];
   logic signed [PL_W-1:0]    pl_in [3][3];
   logic signed [PH_W-1:0]    ph_ff [3][3];
   logic signed [PH_W-1:0]    ph_in [3][3];
   logic signed [TERM_W-1:0]  term_ff [3][3];
   logic signed [TERM_W-1:0]  term_in [3][3];
   logic [2:0][COORD_W-1:0]   res_ff;
   logic [2:0][COORD_W-1:0]   res_in;
   tag_type                   tag_ff [3];

   always_comb begin
      rdy[2]   = !vld_ff[2] || out_ready;
      rdy[1]   = !vld_ff[1] || rdy[2];
      rdy[0]   = !vld_ff[0] || rdy[1];
      in_ready = rdy[0];
   end

   // f = fh * 2^21 + fl, fl unsigned
   always_comb begin
      logic signed [SPLIT_W:0]         fl;
      logic signed [ACC_W-SPLIT_W-1:0] fh;
      fl = '0;
      fh = '0;
      for (int k = 0; k < 3; k++) begin
         fl = $signed({1'b0, in_f[k][SPLIT_W-1:0]});
         fh = $signed(in_f[k][ACC_W-1:SPLIT_W]);
         for (int j = 0; j < 3; j++) begin
            pl_in[j][k] = coef_of(cfg.m2[j], 2'(k)) * fl;
            ph_in[j][k] = coef_of(cfg.m2[j], 2'(k)) * fh;
         end
      end
   end

   always_comb begin
      logic signed [PROD2_W-1:0] full;
      full = '0;
      for (int j = 0; j < 3; j++) begin
         for (int k = 0; k < 3; k++) begin
            full = (PROD2_W'(ph_ff[j][k]) <<< SPLIT_W) + PROD2_W'(pl_ff[j][k]);
            term_in[j][k] = TERM_W'(full >>> FRAC_DROP);
         end
      end
   end

   always_comb begin
      logic signed [SUM_W-1:0] s;
      s = '0;
      for (int j = 0; j < 3; j++) begin
         s = SUM_W'(term_ff[j][0]) + SUM_W'(term_ff[j][1]) + SUM_W'(term_ff[j][2]);
         if (s > SUM_W'(COORD_MAX)) begin
            res_in[j] = COORD_MAX;
         end else if (s < SUM_W'(COORD_MIN)) begin
            res_in[j] = COORD_MIN;
         end else begin
            res_in[j] = COORD_W'(s);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (rdy[0]) vld_ff[0] <= in_valid;
         if (rdy[1]) vld_ff[1] <= vld_ff[0];
         if (rdy[2]) vld_ff[2] <= vld_ff[1];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         pl_ff     <= pl_in;
         ph_ff     <= ph_in;
         tag_ff[0] <= in_tag;
      end
      if (rdy[1]) begin
         term_ff   <= term_in;
         tag_ff[1] <= tag_ff[0];
      end
      if (rdy[2]) begin
         res_ff    <= res_in;
         tag_ff[2] <= tag_ff[1];
      end
   end

   assign out_valid = vld_ff[2];
   assign out_r     = res_ff;
   assign out_tag   = tag_ff[2];

   `SCT_ASSERT(a_block_only_when_full, !in_ready |-> (&vld_ff), "input held back with a free stage")
   `SCT_ASSERT_ALWAYS(a_empty_after_reset, reset |=> (vld_ff == 3'b000), "stage valid after reset")
   `SCT_ASSERT(a_result_held, (vld_ff[2] && !out_ready) |=> (vld_ff[2] && $stable(res_ff)), "stalled result lost")

endmodule

// ----- hdl/symmetry_coordinate_transform_unit.sv -----
// Top level of the symmetry coordinate transform: config registers and six-stage datapath.
//
// Applies one crystallographic symmetry operation per atom word: f = R1*p + T1,
// each component wrapped toward the unit cell (above 1.0 subtract 1.0, below -1.0
// add 2.0, below 0 add 1.0), then T2 subtracted and R2*f returned, saturated to
// signed Q16.16. Slot and last flag ride along unchanged. Coordinates are signed
// Q16.16; matrices and translations are three signed Q6.14 values per 63-bit
// register, column zero in the low bits. Every product is floored to 16 fraction
// bits before summing. The datapath is six register stages deep between req_ and
// rsp_; it takes one word every cycle while rsp_ does not stall, and each stage
// holds its word independently, so a stalled rsp_ side only blocks req_ once all
// six stages are full. The multiplier lanes, 21-by-32-bit for R1 and the split
// 21-by-21 and 21-by-22-bit lanes for R2, each take a stage of their own.
// Registers are written over csr_ (always ready) and must only change while no
// word is in flight.
module symmetry_coordinate_transform_unit
   import sct_pkg::*;
(
   input  logic              clock,
   input  logic              reset,

   // input words
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [COORD_W-1:0] req_coord_x,
   input  logic [COORD_W-1:0] req_coord_y,
   input  logic [COORD_W-1:0] req_coord_z,
   input  logic [SLOT_W-1:0] req_target_slot,
   input  logic              req_last_atom,

   // result words
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [COORD_W-1:0] rsp_result_x,
   output logic [COORD_W-1:0] rsp_result_y,
   output logic [COORD_W-1:0] rsp_result_z,
   output logic [SLOT_W-1:0] rsp_result_slot,
   output logic              rsp_result_last,

   // configuration writes
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [IDX_W-1:0]  csr_index,
   input  logic [REG_W-1:0]  csr_data
);

   cfg_type                 cfg;
   logic [2:0][COORD_W-1:0] in_p;
   tag_type                 in_tag;
   logic                    mid_valid;
   logic                    mid_ready;
   logic [2:0][ACC_W-1:0]   mid_f;
   tag_type                 mid_tag;
   logic [2:0][COORD_W-1:0] out_r;
   tag_type                 out_tag;

   // pack the input word
   always_comb begin
      in_p[0]     = req_coord_x;
      in_p[1]     = req_coord_y;
      in_p[2]     = req_coord_z;
      in_tag.slot = req_target_slot;
      in_tag.last = req_last_atom;
   end

   sct_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // R1 product, T1, wrap, T2
   sct_first_xform u_first (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_p      (in_p),
      .in_tag    (in_tag),
      .out_valid (mid_valid),
      .out_ready (mid_ready),
      .out_f     (mid_f),
      .out_tag   (mid_tag)
   );

   // R2 product, floor, saturate; last stage is the output register
   sct_second_xform u_second (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (mid_valid),
      .in_ready  (mid_ready),
      .in_f      (mid_f),
      .in_tag    (mid_tag),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_r     (out_r),
      .out_tag   (out_tag)
   );

   // unpack the result word
   always_comb begin
      rsp_result_x    = out_r[0];
      rsp_result_y    = out_r[1];
      rsp_result_z    = out_r[2];
      rsp_result_slot = out_tag.slot;
      rsp_result_last = out_tag.last;
   end

endmodule
